>>> hdl/hhc_pkg.sv
package hhc_pkg;

    localparam int unsigned IntervalWidth = 22;
    localparam int unsigned TimeWidth     = 32;
    localparam int unsigned HourWidth     = 5;
    localparam int unsigned HumWidth      = 10;
    localparam int unsigned BandWidth     = 8;
    localparam int unsigned ErrWidth      = 8;
    localparam int unsigned CfgIdxWidth   = 3;
    localparam int unsigned CfgDataWidth  = 22;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_FAST_INTERVAL = 3'd0,
        REG_SLOW_INTERVAL = 3'd1,
        REG_WINDOW_START  = 3'd2,
        REG_WINDOW_END    = 3'd3,
        REG_HUMIDITY_LOW  = 3'd4,
        REG_HUMIDITY_HIGH = 3'd5,
        REG_HYST_BAND     = 3'd6,
        REG_ERROR_LIMIT   = 3'd7
    } cfg_index_t;

    localparam logic [IntervalWidth-1:0] FastIntervalReset = 22'd3000;
    localparam logic [IntervalWidth-1:0] SlowIntervalReset = 22'd600000;
    localparam logic [HourWidth-1:0]     WindowStartReset  = 5'd10;
    localparam logic [HourWidth-1:0]     WindowEndReset    = 5'd21;
    localparam logic [HumWidth-1:0]      HumidityLowReset  = 10'd400;
    localparam logic [HumWidth-1:0]      HumidityHighReset = 10'd700;
    localparam logic [BandWidth-1:0]     HystBandReset     = 8'd50;
    localparam logic [ErrWidth-1:0]      ErrorLimitReset   = 8'd10;
    localparam logic [ErrWidth-1:0]      ErrMax            = 8'hFF;

    typedef struct packed {
        logic [IntervalWidth-1:0] fast_interval_ms;
        logic [IntervalWidth-1:0] slow_interval_ms;
        logic [HourWidth-1:0]     window_start_hour;
        logic [HourWidth-1:0]     window_end_hour;
        logic [HumWidth-1:0]      humidity_low;
        logic [HumWidth-1:0]      humidity_high;
        logic [BandWidth-1:0]     hysteresis_band;
        logic [ErrWidth-1:0]      error_limit;
    } cfg_t;

    typedef struct packed {
        logic [TimeWidth-1:0] now_ms;
        logic [HourWidth-1:0] clock_hour;
        logic                 master_enable;
        logic                 led_enable;
        logic                 pump_enable;
        logic                 fan_enable;
        logic                 read_ok;
        logic [HumWidth-1:0]  humidity_reading;
    } item_t;

    typedef struct packed {
        logic led_on;
        logic pump_on;
        logic fan_on;
        logic sample_taken;
        logic read_failed;
        logic fast_blink;
        logic fault;
        logic fast_rate;
    } result_t;

endpackage

>>> hdl/hhc_req_if.sv
interface hhc_req_if;
    logic                            valid;
    logic                            ready;
    logic [hhc_pkg::TimeWidth-1:0]   now_ms;
    logic [hhc_pkg::HourWidth-1:0]   clock_hour;
    logic                            master_enable;
    logic                            led_enable;
    logic                            pump_enable;
    logic                            fan_enable;
    logic                            read_ok;
    logic [hhc_pkg::HumWidth-1:0]    humidity_reading;

    modport source (
        output valid, now_ms, clock_hour, master_enable, led_enable,
               pump_enable, fan_enable, read_ok, humidity_reading,
        input  ready
    );
    modport sink (
        input  valid, now_ms, clock_hour, master_enable, led_enable,
               pump_enable, fan_enable, read_ok, humidity_reading,
        output ready
    );
endinterface

>>> hdl/hhc_rsp_if.sv
interface hhc_rsp_if;
    logic valid;
    logic ready;
    logic led_on;
    logic pump_on;
    logic fan_on;
    logic sample_taken;
    logic read_failed;
    logic fast_blink;
    logic fault;
    logic fast_rate;

    modport source (
        output valid, led_on, pump_on, fan_on, sample_taken, read_failed,
               fast_blink, fault, fast_rate,
        input  ready
    );
    modport sink (
        input  valid, led_on, pump_on, fan_on, sample_taken, read_failed,
               fast_blink, fault, fast_rate,
        output ready
    );
endinterface

>>> hdl/hhc_cfg_if.sv
interface hhc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [hhc_pkg::CfgIdxWidth-1:0]     index;
    logic [hhc_pkg::CfgDataWidth-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> hdl/hhc_cfg_regs.sv
module hhc_cfg_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    hhc_cfg_if.sink              cfg,
    output hhc_pkg::cfg_t        cfg_out
);

    hhc_pkg::cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_interval_ms  <= hhc_pkg::FastIntervalReset;
            cfg_reg.slow_interval_ms  <= hhc_pkg::SlowIntervalReset;
            cfg_reg.window_start_hour <= hhc_pkg::WindowStartReset;
            cfg_reg.window_end_hour   <= hhc_pkg::WindowEndReset;
            cfg_reg.humidity_low      <= hhc_pkg::HumidityLowReset;
            cfg_reg.humidity_high     <= hhc_pkg::HumidityHighReset;
            cfg_reg.hysteresis_band   <= hhc_pkg::HystBandReset;
            cfg_reg.error_limit       <= hhc_pkg::ErrorLimitReset;
        end
        else if (cfg.valid)
        begin
            unique case (hhc_pkg::cfg_index_t'(cfg.index))
                hhc_pkg::REG_FAST_INTERVAL:
                    cfg_reg.fast_interval_ms  <= cfg.data[hhc_pkg::IntervalWidth-1:0];
                hhc_pkg::REG_SLOW_INTERVAL:
                    cfg_reg.slow_interval_ms  <= cfg.data[hhc_pkg::IntervalWidth-1:0];
                hhc_pkg::REG_WINDOW_START:
                    cfg_reg.window_start_hour <= cfg.data[hhc_pkg::HourWidth-1:0];
                hhc_pkg::REG_WINDOW_END:
                    cfg_reg.window_end_hour   <= cfg.data[hhc_pkg::HourWidth-1:0];
                hhc_pkg::REG_HUMIDITY_LOW:
                    cfg_reg.humidity_low      <= cfg.data[hhc_pkg::HumWidth-1:0];
                hhc_pkg::REG_HUMIDITY_HIGH:
                    cfg_reg.humidity_high     <= cfg.data[hhc_pkg::HumWidth-1:0];
                hhc_pkg::REG_HYST_BAND:
                    cfg_reg.hysteresis_band   <= cfg.data[hhc_pkg::BandWidth-1:0];
                hhc_pkg::REG_ERROR_LIMIT:
                    cfg_reg.error_limit       <= cfg.data[hhc_pkg::ErrWidth-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

>>> hdl/hhc_core.sv
module hhc_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  hhc_pkg::item_t       item,
    input  hhc_pkg::cfg_t        cfg,
    output hhc_pkg::result_t     result
);

    logic                            pump_reg, pump_next;
    logic                            fan_reg, fan_next;
    logic                            retry_reg, retry_next;
    logic [hhc_pkg::ErrWidth-1:0]    errors_reg, errors_next;
    logic [hhc_pkg::TimeWidth-1:0]   last_time_reg, last_time_next;
    logic                            first_due_reg, first_due_next;
    logic [hhc_pkg::HumWidth-1:0]    humidity_reg, humidity_next;
    logic                            blink_reg, blink_next;
    logic                            fault_reg, fault_next;

    logic                            in_window;
    logic                            fast;
    logic [hhc_pkg::IntervalWidth-1:0] interval;
    logic [hhc_pkg::TimeWidth-1:0]   elapsed;
    logic                            due;
    logic [hhc_pkg::HumWidth-1:0]    hum_use;
    logic signed [11:0]              h_s;
    logic signed [11:0]              lo_s;
    logic signed [11:0]              lo_off_s;
    logic signed [11:0]              hi_on_s;
    logic                            led;
    logic                            sampled;
    logic                            failed;
    logic                            fast_out;

    assign in_window = (item.clock_hour >= cfg.window_start_hour)
                    && (item.clock_hour < cfg.window_end_hour);
    assign fast      = pump_reg || fan_reg || retry_reg;
    assign interval  = fast ? cfg.fast_interval_ms : cfg.slow_interval_ms;
    assign elapsed   = item.now_ms - last_time_reg;
    assign due       = first_due_reg
                    || (elapsed >= {{(hhc_pkg::TimeWidth-hhc_pkg::IntervalWidth){1'b0}},
                                    interval});
    assign hum_use   = (due && item.read_ok) ? item.humidity_reading : humidity_reg;
    assign h_s       = $signed({2'b00, hum_use});
    assign lo_s      = $signed({2'b00, cfg.humidity_low});
    assign lo_off_s  = $signed({2'b00, cfg.humidity_high}) - $signed({4'b0000, cfg.hysteresis_band});
    assign hi_on_s   = $signed({2'b00, cfg.humidity_high}) + $signed({4'b0000, cfg.hysteresis_band});

    always_comb
    begin
        pump_next      = pump_reg;
        fan_next       = fan_reg;
        retry_next     = retry_reg;
        errors_next    = errors_reg;
        last_time_next = last_time_reg;
        first_due_next = first_due_reg;
        humidity_next  = humidity_reg;
        blink_next     = blink_reg;
        fault_next     = fault_reg;
        led            = 1'b0;
        sampled        = 1'b0;
        failed         = 1'b0;
        fast_out       = retry_reg;

        priority if (fault_reg)
        begin
            fast_out = 1'b1;
        end
        else if (!item.master_enable)
        begin
            pump_next = 1'b0;
            fan_next  = 1'b0;
        end
        else if (!in_window)
        begin
            led       = item.led_enable;
            pump_next = 1'b0;
            fan_next  = 1'b0;
        end
        else
        begin
            led      = item.led_enable;
            fast_out = fast;
            if (due)
            begin
                sampled        = 1'b1;
                last_time_next = item.now_ms;
                first_due_next = 1'b0;
            end
            if (due && !item.read_ok)
            begin
                failed      = 1'b1;
                errors_next = (errors_reg == hhc_pkg::ErrMax) ? errors_reg
                                                               : errors_reg + 1'b1;
                blink_next  = 1'b1;
                retry_next  = 1'b1;
                pump_next   = 1'b0;
                fan_next    = 1'b0;
                fault_next  = (errors_next >= cfg.error_limit);
            end
            else
            begin
                if (due)
                begin
                    humidity_next = item.humidity_reading;
                    errors_next   = '0;
                    retry_next    = 1'b0;
                    blink_next    = 1'b0;
                end
                priority if (!item.pump_enable) pump_next = 1'b0;
                else if (h_s < lo_s)            pump_next = 1'b1;
                else if (h_s > lo_off_s)        pump_next = 1'b0;
                else                            pump_next = pump_reg;
                priority if (!item.fan_enable)  fan_next = 1'b0;
                else if (h_s > hi_on_s)         fan_next = 1'b1;
                else if (h_s <= lo_off_s)       fan_next = 1'b0;
                else                            fan_next = fan_reg;
            end
        end
    end

    always_comb
    begin
        result.led_on       = led;
        result.pump_on      = pump_next && !fault_reg;
        result.fan_on       = fan_next && !fault_reg;
        result.sample_taken = sampled;
        result.read_failed  = failed;
        result.fast_blink   = blink_next || fault_reg;
        result.fault        = fault_next;
        result.fast_rate    = fast_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pump_reg      <= 1'b0;
            fan_reg       <= 1'b0;
            retry_reg     <= 1'b0;
            errors_reg    <= '0;
            last_time_reg <= '0;
            first_due_reg <= 1'b1;
            blink_reg     <= 1'b0;
            fault_reg     <= 1'b0;
        end
        else if (fire)
        begin
            pump_reg      <= pump_next;
            fan_reg       <= fan_next;
            retry_reg     <= retry_next;
            errors_reg    <= errors_next;
            last_time_reg <= last_time_next;
            first_due_reg <= first_due_next;
            blink_reg     <= blink_next;
            fault_reg     <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            humidity_reg <= humidity_next;
        end
    end

endmodule

>>> hdl/humidity_hysteresis_controller_unit.sv
// An accepted input word is registered in item_reg, its result word in result_reg.
// Throughput: one word per cycle; the input register, one pass of compare
// logic and the result register set it, and a stalled result holds the pass.
// Reset: rst_n, asynchronous, active low; clears both pipeline valids, the
// controller state and loads the register defaults. Stored humidity is not reset.
module humidity_hysteresis_controller_unit (
    input  logic        clk,
    input  logic        rst_n,
    hhc_req_if.sink     req,
    hhc_rsp_if.source   rsp,
    hhc_cfg_if.sink     cfg
);

    hhc_pkg::cfg_t     cfg_val;
    hhc_pkg::item_t    item_reg;
    logic              item_valid_reg;
    hhc_pkg::result_t  result;
    hhc_pkg::result_t  result_reg;
    logic              result_valid_reg;
    logic              advance;
    logic              fire;

    assign advance   = !result_valid_reg || rsp.ready;
    assign fire      = advance && item_valid_reg;
    assign req.ready = !item_valid_reg || advance;

    hhc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val)
    );

    hhc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg_val),
        .result (result)
    );

    // hold the input word until the pass can move it on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                item_valid_reg <= req.valid;
            end
            if (advance)
            begin
                result_valid_reg <= item_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.now_ms           <= req.now_ms;
            item_reg.clock_hour       <= req.clock_hour;
            item_reg.master_enable    <= req.master_enable;
            item_reg.led_enable       <= req.led_enable;
            item_reg.pump_enable      <= req.pump_enable;
            item_reg.fan_enable       <= req.fan_enable;
            item_reg.read_ok          <= req.read_ok;
            item_reg.humidity_reading <= req.humidity_reading;
        end
        if (fire)
        begin
            result_reg <= result;
        end
    end

    assign rsp.valid        = result_valid_reg;
    assign rsp.led_on       = result_reg.led_on;
    assign rsp.pump_on      = result_reg.pump_on;
    assign rsp.fan_on       = result_reg.fan_on;
    assign rsp.sample_taken = result_reg.sample_taken;
    assign rsp.read_failed  = result_reg.read_failed;
    assign rsp.fast_blink   = result_reg.fast_blink;
    assign rsp.fault        = result_reg.fault;
    assign rsp.fast_rate    = result_reg.fast_rate;

endmodule

>>> sim/humidity_hysteresis_controller_unit_tb.sv
`timescale 1ns / 1ps

module humidity_hysteresis_controller_unit_tb;
    import hhc_pkg::*;

    typedef struct {
        item_t   w;
        bit      typed;
        result_t r;
    } opening_row_t;

    logic clk;
    logic rst_n;

    hhc_req_if req_if ();
    hhc_rsp_if rsp_if ();
    hhc_cfg_if cfg_if ();

    humidity_hysteresis_controller_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    cfg_t                 settings;
    bit                   pump_st;
    bit                   fan_st;
    bit                   retry_st;
    bit                   first_due;
    bit                   blink_st;
    bit                   fault_st;
    bit                   hum_known;
    int unsigned          err_run;
    logic [TimeWidth-1:0] last_ms;
    logic [HumWidth-1:0]  hum_stored;
    logic [TimeWidth-1:0] clock_ms;

    result_t      drive_q[$];
    opening_row_t opening_rows[$];

    int mismatches;
    int words_sent;
    int words_checked;
    int samples;
    int failed_reads;
    int halted_words;
    int stall_odds;
    int gap_odds;
    bit fault_allowed;

    string field_name [8] = '{"fast_rate", "fault", "fast_blink", "read_failed",
                              "sample_taken", "fan_on", "pump_on", "led_on"};

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("humidity_hysteresis_controller_unit_tb: done, errors");
        $finish;
    end

    function automatic bit in_window(item_t w);
        return w.clock_hour >= settings.window_start_hour &&
               w.clock_hour < settings.window_end_hour;
    endfunction

    function automatic bit fast_now();
        return pump_st || fan_st || retry_st;
    endfunction

    function automatic logic [TimeWidth-1:0] interval_now();
        return fast_now() ? TimeWidth'(settings.fast_interval_ms)
                          : TimeWidth'(settings.slow_interval_ms);
    endfunction

    function automatic bit sample_due(item_t w);
        logic [TimeWidth-1:0] elapsed;
        elapsed = w.now_ms - last_ms;
        return !fault_st && w.master_enable && in_window(w) &&
               (first_due || elapsed >= interval_now());
    endfunction

    task automatic run_pass(input item_t w, output result_t r);
        int h;
        int lo_off;
        int hi_on;
        bit control;
        r = '0;
        if (fault_st)
        begin
            r.fast_blink = 1'b1;
            r.fault      = 1'b1;
            r.fast_rate  = 1'b1;
            halted_words++;
            return;
        end
        if (!w.master_enable || !in_window(w))
        begin
            pump_st     = 1'b0;
            fan_st      = 1'b0;
            r.led_on    = w.master_enable & w.led_enable;
            r.fast_rate = retry_st;
        end
        else
        begin
            r.led_on    = w.led_enable;
            r.fast_rate = fast_now();
            control     = 1'b1;
            if (sample_due(w))
            begin
                r.sample_taken = 1'b1;
                samples++;
                last_ms   = w.now_ms;
                first_due = 1'b0;
                if (w.read_ok)
                begin
                    hum_stored = w.humidity_reading;
                    hum_known  = 1'b1;
                    err_run    = 0;
                    retry_st   = 1'b0;
                    blink_st   = 1'b0;
                end
                else
                begin
                    r.read_failed = 1'b1;
                    failed_reads++;
                    if (err_run < 255)
                        err_run++;
                    blink_st = 1'b1;
                    retry_st = 1'b1;
                    pump_st  = 1'b0;
                    fan_st   = 1'b0;
                    if (err_run >= settings.error_limit)
                        fault_st = 1'b1;
                    control = 1'b0;
                end
            end
            if (control)
            begin
                h      = int'(hum_stored);
                lo_off = int'(settings.humidity_high) - int'(settings.hysteresis_band);
                hi_on  = int'(settings.humidity_high) + int'(settings.hysteresis_band);
                if (!w.pump_enable)
                    pump_st = 1'b0;
                else if (h < int'(settings.humidity_low))
                    pump_st = 1'b1;
                else if (h > lo_off)
                    pump_st = 1'b0;
                if (!w.fan_enable)
                    fan_st = 1'b0;
                else if (h > hi_on)
                    fan_st = 1'b1;
                else if (h <= lo_off)
                    fan_st = 1'b0;
            end
        end
        r.pump_on    = pump_st;
        r.fan_on     = fan_st;
        r.fast_blink = blink_st;
        r.fault      = fault_st;
    endtask

    // keep control off a humidity that was never read, and the fault out of reach unless fault_allowed is set
    function automatic item_t shape(item_t w);
        if (!fault_allowed && sample_due(w) && err_run + 1 >= settings.error_limit)
            w.read_ok = 1'b1;
        if (!hum_known && !(sample_due(w) && w.read_ok))
        begin
            w.pump_enable = 1'b0;
            w.fan_enable  = 1'b0;
        end
        return w;
    endfunction

    function automatic item_t make_word();
        item_t                w;
        logic [TimeWidth-1:0] ivl;
        logic [TimeWidth-1:0] step;
        int                   lo_off;
        int                   hi_on;
        int                   pick;
        int                   val;
        ivl = interval_now();
        case ($urandom_range(0, 9))
            0:       step = '0;
            1:       step = ivl - 1;
            2, 3:    step = ivl;
            4:       step = ivl + 1;
            5, 6:    step = $urandom_range(0, 2 * ivl);
            7:       step = $urandom_range(0, 3);
            8:       step = $urandom;
            default:
            begin
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 8);
                step     = '0;
            end
        endcase
        clock_ms += step;
        w.now_ms = clock_ms;
        pick = $urandom_range(0, 9);
        if (pick < 7 && settings.window_start_hour < settings.window_end_hour)
            w.clock_hour = HourWidth'($urandom_range(settings.window_start_hour,
                                                     settings.window_end_hour - 1));
        else if (pick == 9)
            w.clock_hour = HourWidth'($urandom_range(0, 31));
        else
            w.clock_hour = HourWidth'($urandom_range(0, 23));
        w.master_enable = ($urandom_range(0, 19) != 0);
        w.led_enable    = 1'($urandom_range(0, 1));
        w.pump_enable   = ($urandom_range(0, 4) != 0);
        w.fan_enable    = ($urandom_range(0, 4) != 0);
        w.read_ok       = fault_allowed ? ($urandom_range(0, 2) != 0)
                                        : ($urandom_range(0, 6) != 0);
        lo_off = int'(settings.humidity_high) - int'(settings.hysteresis_band);
        hi_on  = int'(settings.humidity_high) + int'(settings.hysteresis_band);
        case ($urandom_range(0, 8))
            0:       val = int'(settings.humidity_low) - 1;
            1:       val = int'(settings.humidity_low);
            2:       val = lo_off;
            3:       val = lo_off + 1;
            4:       val = hi_on;
            5:       val = hi_on + 1;
            8:       val = $urandom_range(0, 1023);
            default: val = $urandom_range(0, 1000);
        endcase
        w.humidity_reading = val[HumWidth-1:0];
        return w;
    endfunction

    function automatic cfg_t random_settings();
        cfg_t c;
        c.fast_interval_ms  = IntervalWidth'($urandom_range(1, 40));
        c.slow_interval_ms  = IntervalWidth'($urandom_range(20, 400));
        c.window_start_hour = HourWidth'($urandom_range(0, 12));
        c.window_end_hour   = HourWidth'($urandom_range(12, 24));
        c.humidity_low      = HumWidth'($urandom_range(0, 600));
        c.humidity_high     = HumWidth'($urandom_range(300, 1000));
        c.hysteresis_band   = BandWidth'($urandom_range(0, 200));
        c.error_limit       = ($urandom_range(0, 3) == 0) ? ErrWidth'($urandom_range(1, 4))
                                                          : ErrWidth'($urandom_range(2, 255));
        return c;
    endfunction

    task automatic add_row(input logic [TimeWidth-1:0] ms, input int hour,
                           input bit m, input bit l, input bit p, input bit f,
                           input bit ok, input int hum, input bit typed,
                           input logic [7:0] r);
        opening_row_t row;
        row.w.now_ms           = ms;
        row.w.clock_hour       = HourWidth'(hour);
        row.w.master_enable    = m;
        row.w.led_enable       = l;
        row.w.pump_enable      = p;
        row.w.fan_enable       = f;
        row.w.read_ok          = ok;
        row.w.humidity_reading = HumWidth'(hum);
        row.typed              = typed;
        row.r                  = r;
        opening_rows.push_back(row);
    endtask

    task automatic put_word(input item_t w, input bit typed, input result_t typed_r);
        result_t r;
        @(negedge clk);
        req_if.valid            <= 1'b1;
        req_if.now_ms           <= w.now_ms;
        req_if.clock_hour       <= w.clock_hour;
        req_if.master_enable    <= w.master_enable;
        req_if.led_enable       <= w.led_enable;
        req_if.pump_enable      <= w.pump_enable;
        req_if.fan_enable       <= w.fan_enable;
        req_if.read_ok          <= w.read_ok;
        req_if.humidity_reading <= w.humidity_reading;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        run_pass(w, r);
        drive_q.push_back(typed ? typed_r : r);
        words_sent++;
    endtask

    task automatic idle_req(input int n);
        repeat (n)
        begin
            @(negedge clk);
            req_if.valid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        while (drive_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CfgDataWidth-1:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            REG_FAST_INTERVAL: settings.fast_interval_ms  = val;
            REG_SLOW_INTERVAL: settings.slow_interval_ms  = val;
            REG_WINDOW_START:  settings.window_start_hour = val[HourWidth-1:0];
            REG_WINDOW_END:    settings.window_end_hour   = val[HourWidth-1:0];
            REG_HUMIDITY_LOW:  settings.humidity_low      = val[HumWidth-1:0];
            REG_HUMIDITY_HIGH: settings.humidity_high     = val[HumWidth-1:0];
            REG_HYST_BAND:     settings.hysteresis_band   = val[BandWidth-1:0];
            REG_ERROR_LIMIT:   settings.error_limit       = val[ErrWidth-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic load_settings(input cfg_t c);
        write_reg(REG_FAST_INTERVAL, CfgDataWidth'(c.fast_interval_ms));
        write_reg(REG_SLOW_INTERVAL, CfgDataWidth'(c.slow_interval_ms));
        write_reg(REG_WINDOW_START, CfgDataWidth'(c.window_start_hour));
        write_reg(REG_WINDOW_END, CfgDataWidth'(c.window_end_hour));
        write_reg(REG_HUMIDITY_LOW, CfgDataWidth'(c.humidity_low));
        write_reg(REG_HUMIDITY_HIGH, CfgDataWidth'(c.humidity_high));
        write_reg(REG_HYST_BAND, CfgDataWidth'(c.hysteresis_band));
        write_reg(REG_ERROR_LIMIT, CfgDataWidth'(c.error_limit));
    endtask

    always @(posedge clk)
    begin : check_drive
        logic [7:0] got_v;
        logic [7:0] want_v;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got_v = {rsp_if.led_on, rsp_if.pump_on, rsp_if.fan_on, rsp_if.sample_taken,
                     rsp_if.read_failed, rsp_if.fast_blink, rsp_if.fault,
                     rsp_if.fast_rate};
            if (drive_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%t: result word %b with nothing pending", $realtime, got_v);
                mismatches++;
            end
            else
            begin
                want_v = drive_q.pop_front();
                words_checked++;
                for (int i = 7; i >= 0; i--)
                begin
                    if (got_v[i] !== want_v[i])
                    begin
                        if (mismatches < 10)
                            $display("%t: word %0d %s expected %b got %b", $realtime,
                                     words_checked, field_name[i], want_v[i], got_v[i]);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin : sink_pacing
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall--;
            end
            else if (stall_odds > 0 && $urandom_range(0, 99) < stall_odds)
            begin
                rsp_if.ready <= 1'b0;
                stall = $urandom_range(1, 18) - 1;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        cfg_t    c;
        cfg_t    plan[$];
        result_t none;
        int      odds_pick[4];
        int      n_items;
        bit      last_phase;

        rst_n                   = 1'b0;
        req_if.valid            = 1'b0;
        req_if.now_ms           = '0;
        req_if.clock_hour       = '0;
        req_if.master_enable    = 1'b0;
        req_if.led_enable       = 1'b0;
        req_if.pump_enable      = 1'b0;
        req_if.fan_enable       = 1'b0;
        req_if.read_ok          = 1'b0;
        req_if.humidity_reading = '0;
        rsp_if.ready            = 1'b0;
        cfg_if.valid            = 1'b0;
        cfg_if.index            = REG_FAST_INTERVAL;
        cfg_if.data             = '0;

        settings = '{FastIntervalReset, SlowIntervalReset, WindowStartReset, WindowEndReset,
                     HumidityLowReset, HumidityHighReset, HystBandReset, ErrorLimitReset};
        pump_st       = 1'b0;
        fan_st        = 1'b0;
        retry_st      = 1'b0;
        first_due     = 1'b1;
        blink_st      = 1'b0;
        fault_st      = 1'b0;
        hum_known     = 1'b0;
        err_run       = 0;
        last_ms       = '0;
        hum_stored    = '0;
        clock_ms      = 32'd10000;
        mismatches    = 0;
        words_sent    = 0;
        words_checked = 0;
        samples       = 0;
        failed_reads  = 0;
        halted_words  = 0;
        stall_odds    = 15;
        gap_odds      = 0;
        fault_allowed = 1'b0;
        none          = '0;
        odds_pick     = '{0, 5, 15, 30};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // result bits: led pump fan sample failed blink fault fast
        add_row(0, 12, 0, 1, 1, 1, 1, 500, 1, 8'b0000_0000);
        add_row(5, 9, 1, 1, 1, 1, 1, 0, 1, 8'b1000_0000);
        add_row(10, 21, 1, 0, 1, 1, 1, 0, 1, 8'b0000_0000);
        add_row(20, 10, 1, 1, 1, 1, 1, 0, 1, 8'b1101_0000);
        add_row(21, 10, 1, 1, 1, 1, 1, 1000, 1, 8'b1100_0001);
        add_row(3021, 15, 1, 1, 1, 1, 1, 1000, 1, 8'b1011_0001);
        add_row(6020, 15, 1, 1, 1, 1, 1, 720, 0, '0);
        add_row(6021, 15, 1, 1, 1, 1, 1, 720, 0, '0);
        add_row(9021, 15, 1, 1, 1, 1, 1, 650, 0, '0);
        add_row(12021, 15, 1, 1, 1, 1, 1, 651, 0, '0);
        add_row(612021, 15, 1, 1, 1, 1, 1, 399, 0, '0);
        add_row(615021, 15, 1, 1, 1, 1, 0, 399, 1, 8'b1001_1101);
        add_row(615022, 15, 0, 1, 1, 1, 0, 0, 0, '0);
        add_row(615023, 22, 1, 1, 1, 1, 1, 0, 0, '0);
        add_row(618020, 20, 1, 1, 1, 1, 1, 400, 0, '0);
        add_row(618021, 20, 1, 0, 1, 1, 1, 400, 0, '0);
        add_row(32'hFFFF_FFFF, 20, 1, 1, 1, 1, 1, 1023, 0, '0);
        add_row(2999, 20, 1, 1, 1, 1, 1, 0, 0, '0);
        add_row(3000, 0, 1, 1, 1, 1, 1, 0, 0, '0);
        add_row(3001, 31, 1, 1, 1, 1, 1, 0, 0, '0);
        add_row(3002, 11, 1, 1, 0, 0, 1, 1000, 0, '0);
        add_row(6002, 11, 1, 0, 1, 1, 0, 512, 0, '0);

        foreach (opening_rows[i])
            put_word(shape(opening_rows[i].w), opening_rows[i].typed, opening_rows[i].r);
        idle_req(1);

        plan.push_back('{22'd0, 22'd0, 5'd0, 5'd24, 10'd0, 10'd0, 8'd0, 8'd255});
        plan.push_back('{22'h3F_FFFF, 22'h3F_FFFF, 5'd23, 5'd31, 10'd1023, 10'd1023,
                         8'd255, 8'd1});
        c = random_settings();
        c.fast_interval_ms  = 22'd1;
        c.slow_interval_ms  = 22'd2;
        c.window_start_hour = 5'd12;
        c.window_end_hour   = 5'd12;
        plan.push_back(c);
        c = random_settings();
        c.window_start_hour = 5'd20;
        c.window_end_hour   = 5'd5;
        plan.push_back(c);
        repeat (5) plan.push_back(random_settings());
        c = random_settings();
        c.error_limit = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(2, 6));
        plan.push_back(c);

        foreach (plan[k])
        begin
            last_phase = (k == plan.size() - 1);
            wait_drained();
            load_settings(plan[k]);
            if (last_phase)
            begin
                stall_odds    = 0;
                gap_odds      = 0;
                fault_allowed = 1'b1;
                n_items       = 130;
            end
            else
            begin
                stall_odds = odds_pick[$urandom_range(0, 3)];
                gap_odds   = odds_pick[$urandom_range(0, 3)];
                n_items    = 110;
            end
            repeat (n_items)
            begin
                put_word(shape(make_word()), 1'b0, none);
                if (gap_odds > 0 && $urandom_range(0, 99) < gap_odds)
                    idle_req($urandom_range(1, 18));
            end
            idle_req(1);
        end

        wait_drained();
        repeat (10) @(posedge clk);

        $display("covered %0d words over %0d setting phases: %0d samples, %0d failed reads",
                 words_sent, plan.size() + 1, samples, failed_reads);
        $display("%0d words answered while halted, %0d words checked, %0d mismatches",
                 halted_words, words_checked, mismatches);
        if (mismatches == 0)
            $display("humidity_hysteresis_controller_unit_tb: done, clean");
        else
            $display("humidity_hysteresis_controller_unit_tb: done, errors");
        $finish;
    end

endmodule

>>> sim.f
hdl/hhc_pkg.sv
hdl/hhc_req_if.sv
hdl/hhc_rsp_if.sv
hdl/hhc_cfg_if.sv
hdl/hhc_cfg_regs.sv
hdl/hhc_core.sv
hdl/humidity_hysteresis_controller_unit.sv
sim/humidity_hysteresis_controller_unit_tb.sv
